### hdl/lgrs_pkg.sv
package lgrs_pkg;

	localparam int CHUNK_SIZE = 8;
	localparam int ROW_W      = CHUNK_SIZE + 2;
	localparam int IDX_W      = $clog2(CHUNK_SIZE);
	localparam int CNT_W      = $clog2(CHUNK_SIZE + 2);
	localparam int NBR_W      = 4;

	// 3x3 window, upper row in the top three bits; center cell excluded
	localparam logic [8:0] NBR_MASK = 9'b111101111;

	typedef struct packed {
		logic [ROW_W-1:0] up;
		logic [ROW_W-1:0] mid;
		logic [ROW_W-1:0] down;
		logic [IDX_W-1:0] idx;
		logic             last;
	} win_t;

	typedef struct packed {
		logic [CHUNK_SIZE-1:0] new_row;
		logic [IDX_W-1:0]      row_index;
		logic                  last_row;
		logic                  all_empty;
	} res_t;

	function automatic logic [NBR_W-1:0] count_nbrs(input logic [8:0] win);
		logic [8:0]       nb;
		logic [NBR_W-1:0] sum;
		nb  = win & NBR_MASK;
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			sum = sum + NBR_W'(nb[i]);
		end
		return sum;
	endfunction

endpackage

### hdl/lgrs_if.sv
interface lgrs_row_if;
	logic                       valid;
	logic                       ready;
	logic [lgrs_pkg::ROW_W-1:0] row_bits;
	logic                       frame_start;

	modport source (output valid, output row_bits, output frame_start, input ready);
	modport sink   (input valid, input row_bits, input frame_start, output ready);
endinterface

interface lgrs_res_if;
	logic                            valid;
	logic                            ready;
	logic [lgrs_pkg::CHUNK_SIZE-1:0] new_row;
	logic [lgrs_pkg::IDX_W-1:0]      row_index;
	logic                            last_row;
	logic                            all_empty;

	modport source (output valid, output new_row, output row_index, output last_row,
		output all_empty, input ready);
	modport sink   (input valid, input new_row, input row_index, input last_row,
		input all_empty, output ready);
endinterface

### hdl/lgrs_window.sv
module lgrs_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [lgrs_pkg::ROW_W-1:0] row,
	input  logic                       start,
	input  logic                       advance,
	output logic                       valid_s1,
	output lgrs_pkg::win_t             win_s1
);

	logic [lgrs_pkg::ROW_W-1:0] upper_q;
	logic [lgrs_pkg::ROW_W-1:0] middle_q;
	logic [lgrs_pkg::CNT_W-1:0] seen_q;
	logic [lgrs_pkg::CNT_W-1:0] idx_full;
	logic                       emit;
	logic                       last;

	assign idx_full = seen_q - lgrs_pkg::CNT_W'(2);
	assign last     = (seen_q == lgrs_pkg::CNT_W'(lgrs_pkg::CHUNK_SIZE + 1));
	assign emit     = !start && (seen_q >= lgrs_pkg::CNT_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= '0;
			middle_q <= '0;
			seen_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance)
				valid_s1 <= 1'b0;
			if (accept) begin
				if (start) begin
					upper_q  <= row;
					middle_q <= '0;
					seen_q   <= lgrs_pkg::CNT_W'(1);
				end else if (seen_q == lgrs_pkg::CNT_W'(1)) begin
					middle_q <= row;
					seen_q   <= lgrs_pkg::CNT_W'(2);
				end else if (emit) begin
					upper_q  <= middle_q;
					middle_q <= row;
					seen_q   <= last ? '0 : seen_q + lgrs_pkg::CNT_W'(1);
					valid_s1 <= 1'b1;
				end
			end
		end
	end

	// window payload, loaded with the transaction that completes it
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			win_s1.up   <= upper_q;
			win_s1.mid  <= middle_q;
			win_s1.down <= row;
			win_s1.idx  <= idx_full[lgrs_pkg::IDX_W-1:0];
			win_s1.last <= last;
		end
	end

endmodule

### hdl/lgrs_stencil.sv
module lgrs_stencil (
	input  lgrs_pkg::win_t                  win,
	output logic [lgrs_pkg::CHUNK_SIZE-1:0] next_row
);

	for (genvar c = 0; c < lgrs_pkg::CHUNK_SIZE; c++) begin : g_cell
		logic [8:0]                 cell_win;
		logic [lgrs_pkg::NBR_W-1:0] cnt;

		assign cell_win = {win.up[c+2:c], win.mid[c+2:c], win.down[c+2:c]};
		assign cnt      = lgrs_pkg::count_nbrs(cell_win);
		assign next_row[c] = (cnt == lgrs_pkg::NBR_W'(3)) ||
			((cnt == lgrs_pkg::NBR_W'(2)) && win.mid[c+1]);
	end

endmodule

### hdl/lgrs_result.sv
module lgrs_result (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic                            taken,
	input  logic [lgrs_pkg::CHUNK_SIZE-1:0] next_row,
	input  logic [lgrs_pkg::IDX_W-1:0]      idx,
	input  logic                            last,
	output logic                            valid_q,
	output lgrs_pkg::res_t                  res_q
);

	logic any_alive_q;
	logic alive_now;

	// the top data row opens a fresh chunk, so ignore what came before
	assign alive_now = ((idx != '0) && any_alive_q) || (next_row != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			any_alive_q <= 1'b0;
		end else begin
			if (taken)
				valid_q <= 1'b0;
			if (load) begin
				valid_q     <= 1'b1;
				any_alive_q <= alive_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.new_row   <= next_row;
			res_q.row_index <= idx;
			res_q.last_row  <= last;
			res_q.all_empty <= last && !alive_now;
		end
	end

endmodule

### hdl/life_generation_row_stencil.sv
// The row below a data row loads the window register; the result register follows.
// One row per cycle unless results stall; top border and first data rows give no result.
// The row register feeds the 3x3 stencil, which feeds the result register.
// Reset (arst_n low) clears the row counter, the live flag and both valid bits,
// leaving the block idle until a row with frame_start arrives.
module life_generation_row_stencil (
	input  logic              clk,
	input  logic              arst_n,
	lgrs_row_if.sink          rows,
	lgrs_res_if.source        results
);

	logic                            accept;
	logic                            advance;
	logic                            valid_s1;
	lgrs_pkg::win_t                  win_s1;
	logic [lgrs_pkg::CHUNK_SIZE-1:0] next_row;
	logic                            res_valid;
	lgrs_pkg::res_t                  res;

	assign advance    = valid_s1 && (!res_valid || results.ready);
	assign rows.ready = !valid_s1 || advance;
	assign accept     = rows.valid && rows.ready;

	lgrs_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.row      (rows.row_bits),
		.start    (rows.frame_start),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.win_s1   (win_s1)
	);

	lgrs_stencil u_stencil (
		.win      (win_s1),
		.next_row (next_row)
	);

	lgrs_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.taken    (results.ready),
		.next_row (next_row),
		.idx      (win_s1.idx),
		.last     (win_s1.last),
		.valid_q  (res_valid),
		.res_q    (res)
	);

	assign results.valid     = res_valid;
	assign results.new_row   = res.new_row;
	assign results.row_index = res.row_index;
	assign results.last_row  = res.last_row;
	assign results.all_empty = res.all_empty;

`ifndef SYNTHESIS
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.last_row |->
			results.row_index == lgrs_pkg::IDX_W'(lgrs_pkg::CHUNK_SIZE - 1))
		else $error("last_row on a result that is not the bottom data row");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.all_empty |-> results.last_row)
		else $error("all_empty set on a result other than the bottom row");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept && valid_s1 |-> advance)
		else $error("row accepted while the window register is held");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> results.valid)
		else $error("window advanced without a result appearing");
`endif

endmodule

### tb/tb_life_generation_row_stencil.sv
module tb_life_generation_row_stencil;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [lgrs_pkg::ROW_W-1:0] bits;
		logic                       start;
		logic                       wait_drain;
	} row_txn_t;

	logic clk;
	logic arst_n;

	lgrs_row_if rows_if ();
	lgrs_res_if res_if ();

	life_generation_row_stencil u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rows    (rows_if),
		.results (res_if)
	);

	row_txn_t       rows_to_send[$];
	lgrs_pkg::res_t gen_rows_expected[$];

	// predictor state
	logic [lgrs_pkg::ROW_W-1:0] upper_q;
	logic [lgrs_pkg::ROW_W-1:0] middle_q;
	int                         rows_in_chunk;
	logic                       chunk_live;

	int  rows_accepted;
	int  results_checked;
	int  chunks_done;
	int  empty_chunks;
	int  errors;
	int  rows_counted;
	bit  drain_set;
	bit  row_taken;
	bit  calm;
	int  stall_left;
	bit  stall_done;

	always #6 clk = ~clk;

	function automatic logic [lgrs_pkg::CHUNK_SIZE-1:0] next_gen(
		input logic [lgrs_pkg::ROW_W-1:0] up,
		input logic [lgrs_pkg::ROW_W-1:0] mid, input logic [lgrs_pkg::ROW_W-1:0] down);
		logic [lgrs_pkg::CHUNK_SIZE-1:0] gen;
		int                              n;
		gen = '0;
		for (int c = 1; c <= lgrs_pkg::CHUNK_SIZE; c++) begin
			n = int'(up[c-1]) + int'(up[c]) + int'(up[c+1]) + int'(mid[c-1]) + int'(mid[c+1])
				+ int'(down[c-1]) + int'(down[c]) + int'(down[c+1]);
			gen[c-1] = (n == 3) || (n == 2 && mid[c]);
		end
		return gen;
	endfunction

	task automatic predict_row(input logic [lgrs_pkg::ROW_W-1:0] row, input logic start);
		lgrs_pkg::res_t r;
		if (start) begin
			upper_q       = row;
			middle_q      = '0;
			rows_in_chunk = 1;
			chunk_live    = 1'b0;
		end else if (rows_in_chunk == 1) begin
			middle_q      = row;
			rows_in_chunk = 2;
		end else if (rows_in_chunk >= 2) begin
			r.new_row   = next_gen(upper_q, middle_q, row);
			r.row_index = lgrs_pkg::IDX_W'(rows_in_chunk - 2);
			r.last_row  = (rows_in_chunk - 2 == lgrs_pkg::CHUNK_SIZE - 1);
			if (r.new_row != '0)
				chunk_live = 1'b1;
			r.all_empty = r.last_row && !chunk_live;
			gen_rows_expected.push_back(r);
			upper_q  = middle_q;
			middle_q = row;
			if (r.last_row) begin
				rows_in_chunk = 0;
				chunk_live    = 1'b0;
				chunks_done++;
				if (r.all_empty)
					empty_chunks++;
			end else begin
				rows_in_chunk++;
			end
		end
		// rows while idle fall through: no result
	endtask

	task automatic push_row(input logic [lgrs_pkg::ROW_W-1:0] bits, input logic start,
		input bit counts);
		row_txn_t t;
		t.bits       = bits;
		t.start      = start;
		t.wait_drain = 1'b0;
		// hold the sender once mid-run until every result is back
		if (!drain_set && start && rows_counted >= 1000) begin
			t.wait_drain = 1'b1;
			drain_set    = 1'b1;
		end
		rows_to_send.push_back(t);
		if (counts)
			rows_counted++;
	endtask

	function automatic logic [lgrs_pkg::ROW_W-1:0] random_row(input int density);
		logic [lgrs_pkg::ROW_W-1:0] r;
		case (density)
			0:       r = lgrs_pkg::ROW_W'($urandom & $urandom & $urandom);
			1:       r = lgrs_pkg::ROW_W'($urandom);
			default: r = lgrs_pkg::ROW_W'($urandom | $urandom);
		endcase
		return r;
	endfunction

	task automatic add_chunk(input int density, input int data_rows, input bit zero_data);
		logic [lgrs_pkg::ROW_W-1:0] r;
		push_row(random_row(density), 1'b1, 1'b1);
		for (int i = 0; i < data_rows; i++) begin
			r = random_row(density);
			if (zero_data)
				r[lgrs_pkg::CHUNK_SIZE:1] = '0;
			push_row(r, 1'b0, 1'b1);
		end
	endtask

	// input side monitor: predict on every accepted transaction
	always @(posedge clk) begin
		if (arst_n && rows_if.valid && rows_if.ready) begin
			predict_row(rows_if.row_bits, rows_if.frame_start);
			rows_to_send.delete(0);
			row_taken = 1'b1;
			rows_accepted++;
		end
	end

	// output side monitor
	always @(posedge clk) begin
		lgrs_pkg::res_t got;
		lgrs_pkg::res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.new_row   = res_if.new_row;
			got.row_index = res_if.row_index;
			got.last_row  = res_if.last_row;
			got.all_empty = res_if.all_empty;
			if (gen_rows_expected.size() == 0) begin
				$display("%0t: unexpected result row=%h idx=%0d last=%b empty=%b", $time,
					got.new_row, got.row_index, got.last_row, got.all_empty);
				errors++;
			end else begin
				want = gen_rows_expected.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected row=%h idx=%0d last=%b empty=%b",
						$time, want.new_row, want.row_index, want.last_row, want.all_empty);
					$display("%0t:          actual   row=%h idx=%0d last=%b empty=%b",
						$time, got.new_row, got.row_index, got.last_row, got.all_empty);
					errors++;
				end
				results_checked++;
			end
		end
	end

	always @(negedge clk)
		calm <= (rows_accepted >= 1300 && rows_accepted < 1650);

	// row driver
	always @(negedge clk) begin
		if (!arst_n) begin
			rows_if.valid <= 1'b0;
		end else if (!rows_if.valid || row_taken) begin
			row_taken = 1'b0;
			if (rows_to_send.size() != 0
				&& !(rows_to_send[0].wait_drain && gen_rows_expected.size() != 0)
				&& (calm || $urandom_range(99) >= 17)) begin
				rows_if.valid       <= 1'b1;
				rows_if.row_bits    <= rows_to_send[0].bits;
				rows_if.frame_start <= rows_to_send[0].start;
			end else begin
				rows_if.valid <= 1'b0;
			end
		end
	end

	// result ready, with one long hold-off so the block backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			res_if.ready <= 1'b0;
			stall_left--;
		end else if (!stall_done && rows_accepted >= 600) begin
			stall_done = 1'b1;
			stall_left = 400;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= calm || $urandom_range(99) >= 17;
		end
	end

	initial begin
		#2_400_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int roll;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		rows_if.valid       = 1'b0;
		rows_if.row_bits    = '0;
		rows_if.frame_start = 1'b0;
		res_if.ready        = 1'b0;
		upper_q             = '0;
		middle_q            = '0;
		rows_in_chunk       = 0;
		chunk_live          = 1'b0;

		// stray row before any chunk: ignored
		push_row('1, 1'b0, 1'b1);
		// everything alive, borders included
		for (int i = 0; i < lgrs_pkg::CHUNK_SIZE + 2; i++)
			push_row('1, i == 0, 1'b1);
		// chunk cut short by a new frame start
		push_row(lgrs_pkg::ROW_W'('b1010101010), 1'b1, 1'b1);
		push_row(lgrs_pkg::ROW_W'('b0111000000), 1'b0, 1'b1);
		push_row(lgrs_pkg::ROW_W'('b0000001110), 1'b0, 1'b1);
		push_row(lgrs_pkg::ROW_W'('b1000000001), 1'b0, 1'b1);
		// empty chunk
		for (int i = 0; i < lgrs_pkg::CHUNK_SIZE + 2; i++)
			push_row('0, i == 0, 1'b1);
		// row after the bottom border: ignored
		push_row(lgrs_pkg::ROW_W'('b0101010101), 1'b0, 1'b1);

		while (rows_counted < 2000) begin
			roll = $urandom_range(99);
			if (roll < 78)
				add_chunk($urandom_range(2), lgrs_pkg::CHUNK_SIZE + 1, 1'b0);
			else if (roll < 84)
				add_chunk(0, lgrs_pkg::CHUNK_SIZE + 1, 1'b1);
			else if (roll < 95)
				add_chunk($urandom_range(2), $urandom_range(lgrs_pkg::CHUNK_SIZE), 1'b0);
			else
				for (int i = 0; i < $urandom_range(3, 1); i++)
					push_row(random_row(1), 1'b0, 1'b0);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rows_to_send.size() != 0 || gen_rows_expected.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d rows, checked %0d result rows over %0d finished chunks (%0d empty).",
			rows_accepted, results_checked, chunks_done, empty_chunks);
		$display("Covered aborted chunks, stray rows, a long output stall and a full drain.");
		if (errors == 0 && gen_rows_expected.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
hdl/lgrs_pkg.sv
hdl/lgrs_if.sv
hdl/lgrs_window.sv
hdl/lgrs_stencil.sv
hdl/lgrs_result.sv
hdl/life_generation_row_stencil.sv
tb/tb_life_generation_row_stencil.sv
